// File: rtl/rcb_pkg.sv
// Package: shared constants and widths for the ray / circle bounce hit test.
`timescale 1ns / 1ps
package rcb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CENTER_W      = 19;
  localparam int RADIUS_W      = 18;
  localparam int SLOPE_W       = 17;
  localparam int OUTCOME_W     = 2;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 8;

  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 17'd37838;

  // multiplier limb width and latency (magnitude, products, rows, sum)
  localparam int CHUNK   = 32;
  localparam int MUL_LAT = 4;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_MISS   = 2'd0,
    OUT_INSIDE = 2'd1,
    OUT_AWAY   = 2'd2,
    OUT_HIT    = 2'd3
  } outcome_t;

  function automatic int imax(input int p, input int q);
    imax = (p > q) ? p : q;
  endfunction

endpackage

// File: rtl/rcb_mul.sv
// Pipelined signed multiplier built from 32x32 limb products.
`timescale 1ns / 1ps
module rcb_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  import rcb_pkg::*;

  localparam int NA = (AW + CHUNK - 1) / CHUNK;
  localparam int NB = (BW + CHUNK - 1) / CHUNK;
  localparam int PW = (NA + NB) * CHUNK;

  logic [NA*CHUNK-1:0]   ma_r, ma_nxt;
  logic [NB*CHUNK-1:0]   mb_r, mb_nxt;
  logic                  neg0_r, neg1_r, neg2_r;
  logic [2*CHUNK-1:0]    pp_r [NA][NB];
  logic [PW-1:0]         row_r [NA];
  logic [PW-1:0]         row_nxt [NA];
  logic [PW-1:0]         sum;
  logic signed [AW+BW-1:0] p_r, p_nxt;

  always_comb begin
    logic [AW-1:0] am;
    logic [BW-1:0] bm;
    am = a[AW-1] ? (~a + 1'b1) : a;
    bm = b[BW-1] ? (~b + 1'b1) : b;
    ma_nxt = (NA*CHUNK)'(am);
    mb_nxt = (NB*CHUNK)'(bm);
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (PW'(pp_r[i][j]) << (j * CHUNK));
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      sum = sum + (row_r[i] << (i * CHUNK));
    end
    p_nxt = neg2_r ? $signed((AW+BW)'(~sum + 1'b1)) : $signed((AW+BW)'(sum));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      neg0_r <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ma_r[i*CHUNK +: CHUNK] * mb_r[j*CHUNK +: CHUNK];
        end
      end
      neg1_r <= neg0_r;
      for (int i = 0; i < NA; i++) begin
        row_r[i] <= row_nxt[i];
      end
      neg2_r <= neg1_r;
      p_r    <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// File: rtl/rcb_dly.sv
// Enabled shift line that delays a word by a fixed number of pipeline steps.
`timescale 1ns / 1ps
module rcb_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

// File: rtl/ray_circle_bounce_hit_test.sv
// Top level: ray / circle bounce hit test, exact fixed-point sign arithmetic.
// Throughput: one trial per cycle unless both buffer beats are full and out_tready
// is low, set by five chained multiplier passes each pipelined over MUL_LAT stages;
// a two-beat output buffer keeps input flowing while a result waits.
// Reset (rst_n low, synchronous): valid line and output buffer emptied,
// beam_slope back to tan 30 degrees.
`timescale 1ns / 1ps
module ray_circle_bounce_hit_test #(
  parameter int FRAC_BITS = rcb_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: center_x [18:0], center_y [37:19], radius [55:38]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rcb_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: hit [0], outcome [2:1], zero fill [7:3]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rcb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // beam_slope write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcb_pkg::SLOPE_W-1:0]       cfg_data
);
  import rcb_pkg::*;

  localparam int L     = MUL_LAT;
  localparam int DEPTH = 5 * L + 4;
  localparam int SW    = SLOPE_W + 1;          // slope as a signed operand
  localparam int XW    = CENTER_W;
  localparam int RW    = RADIUS_W + 1;
  localparam int AW    = imax(2 * FRAC_BITS, 2 * SLOPE_W) + 2;
  localparam int HW    = imax(FRAC_BITS + XW, SW + XW) + 1;
  localparam int R2W   = 2 * RW;
  localparam int C0W   = 2 * XW + 2;
  localparam int QW    = imax(2 * HW, AW + C0W) + 1;
  localparam int T1W   = imax(AW + R2W, QW + 1) + 1;
  localparam int T2W   = imax(SW + HW, AW + XW) + 1;
  localparam int EW    = SW + T1W;
  localparam int GW    = T2W + 1;
  localparam int RHW   = 2 * GW + QW;
  localparam int CMPW  = imax(2 * EW, RHW) + 1;

  localparam logic signed [AW-1:0] K2 = $signed(AW'(1) << (2 * FRAC_BITS));

  // ---------------------------------------------------------------- control
  logic              en;
  logic [DEPTH-1:0]  vld_r, vld_nxt;
  logic [SLOPE_W-1:0] slope_r;
  logic signed [SW-1:0] s;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              wr_ptr_r, rd_ptr_r;
  logic [2:0]        buf_r [2];
  logic              push, pop;
  logic [2:0]        res;

  assign s         = $signed({1'b0, slope_r});
  assign cfg_ready = 1'b1;
  // pipeline moves as long as the output buffer can take a beat
  assign en        = (cnt_r != 2'd2) || out_tready;
  assign in_tready = en;
  assign vld_nxt   = {vld_r[DEPTH-2:0], in_tvalid};
  assign push      = en && vld_r[DEPTH-1];
  assign pop       = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r  <= SLOPE_RESET;
      vld_r    <= '0;
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        slope_r <= cfg_data;
      end
      if (en) begin
        vld_r <= vld_nxt;
      end
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {5'd0, buf_r[rd_ptr_r]};

  // ---------------------------------------------------------------- input
  logic signed [XW-1:0] cx, cy;
  logic signed [RW-1:0] rad;

  assign cx  = $signed(in_tdata[18:0]);
  assign cy  = $signed(in_tdata[37:19]);
  assign rad = $signed({1'b0, in_tdata[55:38]});

  // pass 1: s*s, s*y, x*x, y*y, r*r
  logic signed [2*SW-1:0] ss;
  logic signed [SW+XW-1:0] sy;
  logic signed [2*XW-1:0] xx, yy;
  logic signed [2*RW-1:0] rr;
  logic [XW-1:0] x_d, y_d;

  rcb_mul #(.AW(SW), .BW(SW)) u_m_ss (.clk, .en, .a(s),   .b(s),   .p(ss));
  rcb_mul #(.AW(SW), .BW(XW)) u_m_sy (.clk, .en, .a(s),   .b(cy),  .p(sy));
  rcb_mul #(.AW(XW), .BW(XW)) u_m_xx (.clk, .en, .a(cx),  .b(cx),  .p(xx));
  rcb_mul #(.AW(XW), .BW(XW)) u_m_yy (.clk, .en, .a(cy),  .b(cy),  .p(yy));
  rcb_mul #(.AW(RW), .BW(RW)) u_m_rr (.clk, .en, .a(rad), .b(rad), .p(rr));

  rcb_dly #(.W(XW), .N(L)) u_d_x (.clk, .en, .d(in_tdata[18:0]),  .q(x_d));
  rcb_dly #(.W(XW), .N(L)) u_d_y (.clk, .en, .d(in_tdata[37:19]), .q(y_d));

  // stage A: a = k^2 + s^2, h = k*x + s*y, c0 = x^2 + y^2 - r^2
  logic signed [AW-1:0]  a_r;
  logic signed [HW-1:0]  h_r;
  logic signed [C0W-1:0] c0_r;
  logic signed [R2W-1:0] r2_r;
  logic signed [XW-1:0]  ya_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r  <= K2 + AW'(ss);
      h_r  <= (HW'($signed(x_d)) <<< FRAC_BITS) + HW'(sy);
      c0_r <= C0W'(xx) + C0W'(yy) - C0W'(rr);
      r2_r <= rr;
      ya_r <= $signed(y_d);
    end
  end

  // pass 2: h*h, a*c0, a*r2, s*h, a*y
  logic signed [2*HW-1:0]    hh;
  logic signed [AW+C0W-1:0]  ac;
  logic signed [AW+R2W-1:0]  ar;
  logic signed [SW+HW-1:0]   sh;
  logic signed [AW+XW-1:0]   ay;
  logic [3:0]                fl_a, fl_d;   // h neg, h zero, c0 neg, c0 zero

  rcb_mul #(.AW(HW), .BW(HW))  u_m_hh (.clk, .en, .a(h_r), .b(h_r),  .p(hh));
  rcb_mul #(.AW(AW), .BW(C0W)) u_m_ac (.clk, .en, .a(a_r), .b(c0_r), .p(ac));
  rcb_mul #(.AW(AW), .BW(R2W)) u_m_ar (.clk, .en, .a(a_r), .b(r2_r), .p(ar));
  rcb_mul #(.AW(SW), .BW(HW))  u_m_sh (.clk, .en, .a(s),   .b(h_r),  .p(sh));
  rcb_mul #(.AW(AW), .BW(XW))  u_m_ay (.clk, .en, .a(a_r), .b(ya_r), .p(ay));

  assign fl_a = {h_r[HW-1], (h_r == '0), c0_r[C0W-1], (c0_r == '0)};
  rcb_dly #(.W(4), .N(L)) u_d_fl (.clk, .en, .d(fl_a), .q(fl_d));

  // stage B: discriminant q, early outcome, t1 = a*r2 - 2q, t2 = s*h - a*y
  logic signed [QW-1:0]  q_nxt, q_r;
  logic signed [T1W-1:0] t1_r;
  logic signed [T2W-1:0] t2_r;
  logic [1:0]            pre_nxt, pre_r;
  logic                  need_nxt, need_r, qz_r;

  always_comb begin
    logic hneg, hzero, cneg, czero;
    {hneg, hzero, cneg, czero} = fl_d;
    q_nxt    = QW'(hh) - QW'(ac);
    need_nxt = 1'b0;
    pre_nxt  = OUT_AWAY;
    if (q_nxt[QW-1]) begin
      pre_nxt = OUT_MISS;
    end else if (czero && !hneg) begin
      pre_nxt = OUT_AWAY;            // nearer root exactly zero
    end else if (!(!hneg && !hzero && !cneg && !czero)) begin
      pre_nxt = OUT_INSIDE;          // nearer root negative
    end else begin
      need_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r    <= q_nxt;
      t1_r   <= T1W'(ar) - (T1W'(q_nxt) <<< 1);
      t2_r   <= T2W'(sh) - T2W'(ay);
      pre_r  <= pre_nxt;
      need_r <= need_nxt;
      qz_r   <= (q_nxt == '0);
    end
  end

  // pass 3: e = s*t1; g = 2*t2 rides alongside
  logic signed [EW-1:0] e;
  logic [T2W-1:0]       t2_d;

  rcb_mul #(.AW(SW), .BW(T1W)) u_m_e (.clk, .en, .a(s), .b(t1_r), .p(e));
  rcb_dly #(.W(T2W), .N(L)) u_d_t2 (.clk, .en, .d(t2_r), .q(t2_d));

  // stage C
  logic signed [EW-1:0] e_r;
  logic signed [GW-1:0] g_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e;
      g_r <= GW'($signed(t2_d)) <<< 1;
    end
  end

  // pass 4: e*e, g*g
  logic signed [2*EW-1:0] ee;
  logic signed [2*GW-1:0] gg;
  logic [QW-1:0]          q_d;

  rcb_mul #(.AW(EW), .BW(EW)) u_m_ee (.clk, .en, .a(e_r), .b(e_r), .p(ee));
  rcb_mul #(.AW(GW), .BW(GW)) u_m_gg (.clk, .en, .a(g_r), .b(g_r), .p(gg));
  rcb_dly #(.W(QW), .N(2*L+1)) u_d_q (.clk, .en, .d(q_r), .q(q_d));

  // stage D
  logic signed [2*EW-1:0] ee_r;
  logic signed [2*GW-1:0] gg_r;
  logic signed [QW-1:0]   qd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ee_r <= ee;
      gg_r <= gg;
      qd_r <= $signed(q_d);
    end
  end

  // pass 5: g^2 * q, compared against e^2
  logic signed [RHW-1:0]  rhs;
  logic [2*EW-1:0]        ee_d;
  logic [3:0]             sg_c, sg_d;      // e neg, e zero, g neg, g zero
  logic [3:0]             pre_c, pre_d;    // code, need, q zero

  rcb_mul #(.AW(2*GW), .BW(QW)) u_m_rhs (.clk, .en, .a(gg_r), .b(qd_r), .p(rhs));
  rcb_dly #(.W(2*EW), .N(L)) u_d_ee (.clk, .en, .d(ee_r), .q(ee_d));

  assign sg_c  = {e_r[EW-1], (e_r == '0), g_r[GW-1], (g_r == '0)};
  assign pre_c = {pre_r, need_r, qz_r};
  rcb_dly #(.W(4), .N(2*L+1)) u_d_sg  (.clk, .en, .d(sg_c),  .q(sg_d));
  rcb_dly #(.W(4), .N(3*L+2)) u_d_pre (.clk, .en, .d(pre_c), .q(pre_d));

  // final decision: sign of e + g*sqrt(q)
  always_comb begin
    logic eneg, ezero, gneg, gzero, qz, need;
    logic signneg;
    logic signed [CMPW-1:0] lhs_w, rhs_w;
    logic [1:0] code;
    {eneg, ezero, gneg, gzero} = sg_d;
    {code, need, qz}           = pre_d;
    lhs_w = CMPW'($signed(ee_d));
    rhs_w = CMPW'(rhs);
    if (gzero || qz) begin
      signneg = eneg;
    end else if (ezero || (eneg == gneg)) begin
      signneg = gneg;
    end else if (lhs_w > rhs_w) begin
      signneg = eneg;
    end else if (lhs_w < rhs_w) begin
      signneg = gneg;
    end else begin
      signneg = 1'b0;                // terms cancel: grazing bounce
    end
    if (need) begin
      code = signneg ? OUT_HIT : OUT_AWAY;
    end
    res = {code, (code == OUT_HIT)};
  end

endmodule

// File: verif/tb_top.sv
// Testbench for the ray / circle bounce hit test: exact sign predictor, random stream traffic.
`timescale 1ns / 1ps
module tb_top;
  import rcb_pkg::*;

  // Wide enough for every intermediate of the exact sign tests (largest is about 2^180).
  typedef logic signed [255:0] wint_t;

  // Holds the outcomes the block owes us, worked out from each accepted trial.
  class bounce_scoreboard;
    logic [SLOPE_W-1:0] slope;
    outcome_t           pending[$];
    int                 n_bad;
    int                 n_seen;

    function new();
      slope = SLOPE_RESET;
      n_bad = 0;
      n_seen = 0;
    endfunction

    static function int sgn(wint_t v);
      return (v == 0) ? 0 : ((v < 0) ? -1 : 1);
    endfunction

    function outcome_t classify(logic signed [CENTER_W-1:0] cx,
                                logic signed [CENTER_W-1:0] cy,
                                logic [RADIUS_W-1:0] rad);
      wint_t x, y, r, s, k, a, h, r2, c0, q, e, g, lhs, rhs;
      int hs, cs, qs, es, gs, sig;
      x = cx;
      y = cy;
      r = {238'd0, rad};
      s = {239'd0, slope};
      k = wint_t'(1) <<< FRAC_BITS_DEF;
      // beam direction (2^16, slope); the quadratic in t is a*t^2 - 2h*t + c0
      a  = k * k + s * s;
      h  = k * x + s * y;
      r2 = r * r;
      c0 = x * x + y * y - r2;
      q  = h * h - a * c0;
      hs = sgn(h);
      cs = sgn(c0);
      qs = sgn(q);
      if (qs < 0) return OUT_MISS;
      if (cs == 0 && hs >= 0) return OUT_AWAY;   // nearer root exactly zero
      if (!(hs > 0 && cs > 0)) return OUT_INSIDE; // nearer root negative
      // mirrored y direction has the sign of e + g*sqrt(q)
      e  = s * (a * r2 - 2 * q);
      g  = 2 * (s * h - a * y);
      es = sgn(e);
      gs = sgn(g);
      if (gs == 0 || qs == 0) sig = es;
      else if (es == 0 || es == gs) sig = gs;
      else begin
        lhs = e * e;
        rhs = g * g * q;
        sig = (lhs > rhs) ? es : ((lhs < rhs) ? gs : 0);
      end
      return (sig < 0) ? OUT_HIT : OUT_AWAY;
    endfunction

    function void note_trial(logic [IN_DATA_W-1:0] d);
      pending.push_back(classify(d[18:0], d[37:19], d[55:38]));
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      outcome_t want;
      logic     want_hit;
      n_seen++;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("result %0d with nothing pending: %h", n_seen, d);
        return;
      end
      want = pending.pop_front();
      want_hit = (want == OUT_HIT);
      if (d[0] !== want_hit || d[2:1] !== want || d[7:3] !== 5'd0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("result %0d: expected hit %0b outcome %0d, got hit %0b outcome %0d (fill %h)",
                   n_seen, want_hit, want, d[0], d[2:1], d[7:3]);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [SLOPE_W-1:0]    cfg_data;

  bounce_scoreboard sb;
  bit               quiet;      // last stretch: no gaps on either side
  int               stall_cnt;
  logic             beat_seen;

  ray_circle_bounce_hit_test i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Handshake lines only move at the rising edge, so the falling edge sees
  // exactly what the next rising edge will accept.
  always @(negedge clk) begin
    beat_seen <= rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                           (cfg_valid && cfg_ready));
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_trial(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Watchdog: too long without any beat on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n || beat_seen) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= 3000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: one long hold-off early on so the pipe backs up into in_tready,
  // then random stall bursts until the quiet stretch.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_tready <= 1'b1;
    repeat (200) @(posedge clk);
    out_tready <= 1'b0;
    repeat (400) @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_trial(input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
                            input logic [RADIUS_W-1:0] rad);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rad, cy, cx};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  // Slope writes only with the pipe drained; extra cycles cover the latency.
  task automatic set_slope(input logic [SLOPE_W-1:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    sb.slope = v;
  endtask

  // Circle centred near the beam line, radius mostly around the offset, so
  // most trials actually meet the circle and the bounce test gets exercised.
  task automatic send_near_beam();
    int   cx, off, rad;
    longint cy;
    cx  = $urandom_range(0, 262143) - (($urandom_range(0, 3) == 0) ? 131072 : 0);
    off = $urandom_range(0, 131071) - 65536;
    cy  = ((longint'(cx) * longint'(sb.slope)) >>> 16) + off;
    rad = (off < 0 ? -off : off) + $urandom_range(0, 40000) - 8000;
    if (rad < 0) rad = -rad;
    send_trial(CENTER_W'(cx), CENTER_W'(cy), RADIUS_W'(rad));
  endtask

  task automatic send_any();
    send_trial(CENTER_W'($urandom), CENTER_W'($urandom), RADIUS_W'($urandom));
  endtask

  initial begin
    logic [SLOPE_W-1:0] slopes[5];
    sb = new();
    quiet     = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed trials at the reset slope
    send_trial(19'h40000, 19'h40000, 18'h3FFFF);  // most negative centre, largest radius
    send_trial(19'h3FFFF, 19'h3FFFF, 18'h3FFFF);
    send_trial(19'h3FFFF, 19'h40000, 18'd1);
    send_trial(19'd0, 19'd0, 18'd1000);            // emitter inside
    send_trial(19'd0, 19'd100000, 18'd10);         // clear miss
    send_trial(19'd50000, 19'd0, 18'd50000);       // circle through origin: root zero
    send_trial(19'h7FFF0, 19'd0, 18'd16);          // through origin, behind
    send_trial(19'd65536, 19'd37838, 18'd0);       // point on beam: zero radius
    send_trial(19'd65536, 19'd40000, 18'd0);       // point off beam
    send_trial(19'h7F000, 19'h7F000, 18'd100);     // circle behind emitter
    send_trial(19'd100000, 19'd120000, 18'd30000); // above beam
    send_trial(19'd100000, 19'd20000, 18'd30000);  // below beam
    send_trial(19'd200000, 19'd115000, 18'd5000);
    send_trial(19'd0, 19'd65536, 18'd32768);       // tangent-ish geometry
    send_trial(19'd131072, 19'd0, 18'd65536);
    repeat (5) send_near_beam();

    slopes[0] = SLOPE_RESET;
    slopes[1] = 17'd0;          // flat beam
    slopes[2] = 17'd131071;     // steepest
    slopes[3] = 17'd1;
    slopes[4] = SLOPE_W'($urandom_range(1, 131071));
    for (int p = 0; p < 5; p++) begin
      if (p > 0) set_slope(slopes[p]);
      if (p == 4) quiet = 1'b1;
      if (p == 1) begin
        // flat beam: horizontal tangent and a point on the axis
        send_trial(19'd100000, 19'd20000, 18'd20000);
        send_trial(19'd100000, 19'd0, 18'd0);
      end
      repeat (386) begin
        if ($urandom_range(0, 3) == 0) send_any();
        else send_near_beam();
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.n_bad == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
